// File: hw/rtl/mcct_pkg.sv
`default_nettype none

package mcct_pkg;

    // pixel and centre geometry
    localparam int CH_W   = 8;
    localparam int NUM_CH = 3;
    localparam int SLOT_W = 3;
    localparam int CNT_W  = 4;

    localparam int DEFAULT_NUM_CENTERS = 8;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // stream packing
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 8;

    localparam logic [CH_W-1:0] CH_MAX = 8'd255;

    // register reset values
    localparam logic [CH_W-1:0]  RST_LOWER_CH0 = 8'd12;
    localparam logic [CH_W-1:0]  RST_LOWER_CH1 = 8'd30;
    localparam logic [CH_W-1:0]  RST_LOWER_CH2 = 8'd80;
    localparam logic [CH_W-1:0]  RST_UPPER_CH0 = 8'd7;
    localparam logic [CH_W-1:0]  RST_UPPER_CH1 = 8'd40;
    localparam logic [CH_W-1:0]  RST_UPPER_CH2 = 8'd80;
    localparam logic [CNT_W-1:0] RST_CENTERS   = 4'd7;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOWER_CH0 = 3'd0,
        REG_LOWER_CH1 = 3'd1,
        REG_LOWER_CH2 = 3'd2,
        REG_UPPER_CH0 = 3'd3,
        REG_UPPER_CH1 = 3'd4,
        REG_UPPER_CH2 = 3'd5,
        REG_CENTERS   = 3'd6
    } cfg_reg_t;

    typedef enum logic {
        KIND_PIXEL = 1'b0,
        KIND_LOAD  = 1'b1
    } kind_t;

    typedef logic [NUM_CH-1:0][CH_W-1:0] pixel_t;

    typedef struct packed {
        pixel_t lower;
        pixel_t upper;
    } margins_t;

endpackage

`default_nettype wire

// File: hw/rtl/mcct_cfg_regs.sv
`default_nettype none

module mcct_cfg_regs
    import mcct_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output margins_t                   margins,
    output logic [CNT_W-1:0]           centers_in_use
);

    margins_t          margins_reg, margins_next;
    logic [CNT_W-1:0]  centers_reg, centers_next;

    always_comb begin
        margins_next = margins_reg;
        centers_next = centers_reg;
        if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_LOWER_CH0: margins_next.lower[0] = cfg_data;
                REG_LOWER_CH1: margins_next.lower[1] = cfg_data;
                REG_LOWER_CH2: margins_next.lower[2] = cfg_data;
                REG_UPPER_CH0: margins_next.upper[0] = cfg_data;
                REG_UPPER_CH1: margins_next.upper[1] = cfg_data;
                REG_UPPER_CH2: margins_next.upper[2] = cfg_data;
                REG_CENTERS:   centers_next = cfg_data[CNT_W-1:0];
                default: ;  // unknown index, write dropped
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            margins_reg.lower[0] <= RST_LOWER_CH0;
            margins_reg.lower[1] <= RST_LOWER_CH1;
            margins_reg.lower[2] <= RST_LOWER_CH2;
            margins_reg.upper[0] <= RST_UPPER_CH0;
            margins_reg.upper[1] <= RST_UPPER_CH1;
            margins_reg.upper[2] <= RST_UPPER_CH2;
            centers_reg          <= RST_CENTERS;
        end else begin
            margins_reg <= margins_next;
            centers_reg <= centers_next;
        end
    end

    assign margins        = margins_reg;
    assign centers_in_use = centers_reg;

endmodule

`default_nettype wire

// File: hw/rtl/mcct_box_lane.sv
`default_nettype none

module mcct_box_lane
    import mcct_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   wr_en,
    input  wire pixel_t wr_center,
    input  wire pixel_t pix,
    input  wire margins_t margins,
    output logic        in_box
);

    pixel_t center_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            center_reg <= wr_center;
        end
    end

    // per-channel box with bounds clamped for this centre only
    always_comb begin
        logic [CH_W:0]   lo_ext;
        logic [CH_W:0]   hi_ext;
        logic [CH_W-1:0] lo;
        logic [CH_W-1:0] hi;
        in_box = 1'b1;
        for (int c = 0; c < NUM_CH; c++) begin
            lo_ext = {1'b0, center_reg[c]} - {1'b0, margins.lower[c]};
            hi_ext = {1'b0, center_reg[c]} + {1'b0, margins.upper[c]};
            lo     = lo_ext[CH_W] ? '0 : lo_ext[CH_W-1:0];
            hi     = hi_ext[CH_W] ? CH_MAX : hi_ext[CH_W-1:0];
            if (pix[c] < lo || pix[c] > hi) begin
                in_box = 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/multi_center_color_threshold_core.sv
// multi-centre colour threshold core (skin mask)
//
// s_ channel takes one request per cycle while s_tready is high. s_tuser is the kind: 0 classifies
// the pixel in s_tdata, 1 loads s_tdata's channels as the centre colour of
// table slot s_tdata[2:0]. loads into slots at or above NUM_CENTERS are dropped.
// every pixel request yields one m_ request whose m_tdata[0] is 1 when the
// pixel lies inside the box of any of the first centers_in_use slots; loads
// yield nothing.
// a pixel is held in the input register, then in the output register that drives m_.
// throughput: one request per clock while m_tready keeps the output free, set by the single compare stage where
// all NUM_CENTERS boxes are checked in parallel.
// the cfg port (always ready) writes margins and centers_in_use; write it only
// while the core holds no request in flight.
// reset (aresetn low, synchronous) empties the pipeline and restores the
// register defaults; the centre table is not cleared and must be loaded
// before its slots are used.
// when m_tready is low the result is held in the output register, a pixel
// waiting behind it holds the input register, and s_tready drops.
`default_nettype none

module multi_center_color_threshold_core
    import mcct_pkg::*;
#(
    parameter int NUM_CENTERS = DEFAULT_NUM_CENTERS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    // pixel / load requests
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // slot, chan0, chan1, chan2, zero pad
    input  wire logic                  s_tuser,   // kind

    // mask results
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,   // in_skin, zero pad

    // register writes
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // wide enough for the slot, the count and every lane number up to 16
    localparam int LANE_IDX_W = CNT_W + 1;

    // unpack the incoming request
    logic [SLOT_W-1:0] s_slot;
    pixel_t            s_pix;

    assign s_slot   = s_tdata[SLOT_W-1:0];
    assign s_pix[0] = s_tdata[SLOT_W +: CH_W];
    assign s_pix[1] = s_tdata[SLOT_W + CH_W +: CH_W];
    assign s_pix[2] = s_tdata[SLOT_W + 2*CH_W +: CH_W];

    // configuration registers
    margins_t          margins;
    logic [CNT_W-1:0]  centers_in_use;

    assign cfg_ready = 1'b1;

    mcct_cfg_regs u_cfg (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .margins        (margins),
        .centers_in_use (centers_in_use)
    );

    // input register stage
    logic              s1_valid_reg, s1_valid_next;
    kind_t             s1_kind_reg;
    logic [SLOT_W-1:0] s1_slot_reg;
    pixel_t            s1_pix_reg;

    // output register stage
    logic              m_valid_reg, m_valid_next;
    logic              m_skin_reg, m_skin_next;

    logic              s_accept;
    logic              out_free;
    logic              s1_adv;
    logic              s1_pixel_adv;
    logic              s1_load;

    assign out_free     = !m_valid_reg || m_tready;
    // a load leaves the input stage at once, a pixel needs room downstream
    assign s1_load      = s1_valid_reg && (s1_kind_reg == KIND_LOAD);
    assign s1_pixel_adv = s1_valid_reg && (s1_kind_reg == KIND_PIXEL) && out_free;
    assign s1_adv       = s1_load || s1_pixel_adv;
    assign s_tready     = !s1_valid_reg || s1_adv;
    assign s_accept     = s_tvalid && s_tready;

    // one lane per table slot: centre storage and box test
    logic [NUM_CENTERS-1:0] lane_inside;
    logic [NUM_CENTERS-1:0] lane_active;

    for (genvar i = 0; i < NUM_CENTERS; i++) begin : g_lane
        logic lane_we;

        assign lane_we = s1_load &&
                         ({{(LANE_IDX_W-SLOT_W){1'b0}}, s1_slot_reg} == LANE_IDX_W'(i));
        // slots past NUM_CENTERS do not exist, so the count saturates here
        assign lane_active[i] =
            ({{(LANE_IDX_W-CNT_W){1'b0}}, centers_in_use} > LANE_IDX_W'(i));

        mcct_box_lane u_lane (
            .aclk      (aclk),
            .wr_en     (lane_we),
            .wr_center (s1_pix_reg),
            .pix       (s1_pix_reg),
            .margins   (margins),
            .in_box    (lane_inside[i])
        );
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        m_skin_next  = m_skin_reg;
        if (out_free) begin
            m_valid_next = s1_pixel_adv;
            m_skin_next  = |(lane_inside & lane_active);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_kind_reg <= kind_t'(s_tuser);
            s1_slot_reg <= s_slot;
            s1_pix_reg  <= s_pix;
        end
        m_skin_reg <= m_skin_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-1){1'b0}}, m_skin_reg};

endmodule

`default_nettype wire
